// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, all sampled on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define I2D_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define I2D_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/i2d_pkg.sv =====
// ---------------------------------------------------------------------------
// i2d_pkg
// Widths, character codes and shared types of the integer to decimal
// ASCII converter.
// ---------------------------------------------------------------------------
package i2d_pkg;

  // Width of the signed input value.
  localparam int DATA_WIDTH = 32;
  localparam int IN_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int CHAR_W     = 8;

  // Double dabble: magnitude bits consumed per cycle.
  localparam int STEP_BITS  = 4;
  localparam int MAG_PAD    = ((DATA_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int NSTEPS     = MAG_PAD / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(NSTEPS + 1);

  // Decimal digits needed for 2^(DATA_WIDTH-1), rounded up.
  localparam int NDIG  = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int POS_W = $clog2(NDIG);

  // Queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  // Classified item: sign and magnitude.
  typedef struct packed {
    logic                  neg;
    logic [DATA_WIDTH-1:0] mag;
  } i2d_item_t;

  // Converted number handed to the emitter.
  typedef struct packed {
    logic             neg;
    logic [POS_W-1:0] top;
    logic [BCD_W-1:0] bcd;
  } i2d_digits_t;

endpackage

// ===== design/i2d_front.sv =====
// ---------------------------------------------------------------------------
// i2d_front
// Accepts input beats, splits the value into sign and magnitude and pushes
// the result into the queue.
// ---------------------------------------------------------------------------
module i2d_front (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2d_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] value
  output logic                              q_push_valid,
  output i2d_pkg::i2d_item_t                q_push_item,
  input  logic                              q_push_ready
);
  import i2d_pkg::*;

  logic [DATA_WIDTH-1:0] raw;

  // Magnitude is formed at full width, so the most negative value is exact.
  always_comb begin
    raw              = in_tdata[DATA_WIDTH-1:0];
    q_push_item.neg  = raw[DATA_WIDTH-1];
    q_push_item.mag  = raw[DATA_WIDTH-1] ? (~raw + 1'b1) : raw;
  end

  assign q_push_valid = in_tvalid;
  assign in_tready    = q_push_ready;

endmodule

// ===== design/i2d_fifo.sv =====
// ---------------------------------------------------------------------------
// i2d_fifo
// Short queue of classified items between the front and the converter.
// Depth is a power of two so the pointers wrap on their own.
// ---------------------------------------------------------------------------
module i2d_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  i2d_pkg::i2d_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output i2d_pkg::i2d_item_t pop_item,
  output logic [i2d_pkg::Q_CW-1:0] fill
);
  import i2d_pkg::*;

  i2d_item_t         entry_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = entry_r[rd_ptr_r];
  assign fill       = cnt_r;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/i2d_conv.sv =====
// ---------------------------------------------------------------------------
// i2d_conv
// Binary to BCD converter: shift-and-add-3 over four magnitude bits per
// cycle, then hands the digits and the leading digit position onward.
// ---------------------------------------------------------------------------
module i2d_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  output logic                item_ready,
  input  i2d_pkg::i2d_item_t  item,
  output logic                dig_valid,
  input  logic                dig_ready,
  output i2d_pkg::i2d_digits_t dig
);
  import i2d_pkg::*;

  localparam logic [STEP_CNT_W-1:0] LAST_CNT = STEP_CNT_W'(NSTEPS);

  logic                  busy_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [MAG_PAD-1:0]    mag_r;
  logic [BCD_W-1:0]      bcd_r;
  logic                  neg_r;
  logic [MAG_PAD-1:0]    mag_nxt;
  logic [BCD_W-1:0]      bcd_nxt;
  logic [POS_W-1:0]      top;
  logic                  done;

  assign done       = busy_r && (cnt_r == LAST_CNT);
  assign item_ready = !busy_r;
  assign dig_valid  = done;

  // Four dependent dabble steps, each over all digits in parallel.
  always_comb begin
    bcd_nxt = bcd_r;
    mag_nxt = mag_r;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_nxt[d*4 +: 4] >= 4'd5) begin
          bcd_nxt[d*4 +: 4] = bcd_nxt[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_nxt, mag_nxt} = {bcd_nxt[BCD_W-2:0], mag_nxt, 1'b0};
    end
  end

  // Highest nonzero digit; zero keeps position 0.
  always_comb begin
    top = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        top = POS_W'(i);
      end
    end
  end

  assign dig.neg = neg_r;
  assign dig.top = top;
  assign dig.bcd = bcd_r;

  // Load, iterate, hand off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (!busy_r) begin
      if (item_valid) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mag_r  <= MAG_PAD'(item.mag);
        bcd_r  <= '0;
        neg_r  <= item.neg;
      end
    end else if (!done) begin
      cnt_r <= cnt_r + 1'b1;
      mag_r <= mag_nxt;
      bcd_r <= bcd_nxt;
    end else if (dig_ready) begin
      busy_r <= 1'b0;
    end
  end

endmodule

// ===== design/i2d_emit.sv =====
// ---------------------------------------------------------------------------
// i2d_emit
// Walks a converted number from its leading digit down, with the minus sign
// first, and drives the output register one character per beat.
// ---------------------------------------------------------------------------
module i2d_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         dig_valid,
  output logic                         dig_ready,
  input  i2d_pkg::i2d_digits_t         dig,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [i2d_pkg::CHAR_W-1:0]   out_tdata,
  output logic                         out_tlast
);
  import i2d_pkg::*;

  logic                busy_r;
  logic                sign_r;
  logic [POS_W-1:0]    pos_r;
  logic [BCD_W-1:0]    bcd_r;
  logic                ovalid_r;
  logic [CHAR_W-1:0]   ochar_r;
  logic                olast_r;
  logic                advance;
  logic [3:0]          digit;

  assign dig_ready  = !busy_r;
  assign advance    = busy_r && (!ovalid_r || out_tready);
  assign digit      = bcd_r[pos_r*4 +: 4];
  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

  // Character sequencing and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (!busy_r) begin
        // While idle, a taken beat empties the output register.
        if (out_tready) begin
          ovalid_r <= 1'b0;
        end
        if (dig_valid) begin
          busy_r <= 1'b1;
          sign_r <= dig.neg;
          pos_r  <= dig.top;
          bcd_r  <= dig.bcd;
        end
      end else if (advance) begin
        ovalid_r <= 1'b1;
        if (sign_r) begin
          ochar_r <= CHAR_MINUS;
          olast_r <= 1'b0;
          sign_r  <= 1'b0;
        end else begin
          ochar_r <= CHAR_ZERO + CHAR_W'(digit);
          olast_r <= (pos_r == '0);
          if (pos_r == '0) begin
            busy_r <= 1'b0;
          end else begin
            pos_r <= pos_r - 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== design/int_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per output beat.
// ---------------------------------------------------------------------------
//  Channel | Dir | tdata              | tlast
//  in_     | in  | [31:0] value       | -
//  out_    | out | [7:0] character    | last character of the number
//
// The converter loads an item, runs 4-bit double dabble over it and hands
// the digits off; the emitter loads them and sends one character per cycle
// while the output is not stalled. Each takes a new number only when done
// with the last, and the converter can work while the emitter sends.
// Reset clears the queue and all control state; there is no clearing pass.
// An output stall holds the output register; the converter and the
// two-entry queue still take input beats until full, then the input stalls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module int_to_decimal_ascii (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [i2d_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [i2d_pkg::CHAR_W-1:0]      out_tdata,  // [7:0] character
  output logic                            out_tlast
);
  import i2d_pkg::*;

  logic        push_valid;
  logic        push_ready;
  i2d_item_t   push_item;
  logic        pop_valid;
  logic        pop_ready;
  i2d_item_t   pop_item;
  logic [Q_CW-1:0] q_fill;
  logic        dig_valid;
  logic        dig_ready;
  i2d_digits_t dig;

  // Front: classify sign and magnitude.
  i2d_front u_front (
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .q_push_valid (push_valid),
    .q_push_item  (push_item),
    .q_push_ready (push_ready)
  );

  // Queue between front and back.
  i2d_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .fill       (q_fill)
  );

  // Back: binary to BCD.
  i2d_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .dig_valid  (dig_valid),
    .dig_ready  (dig_ready),
    .dig        (dig)
  );

  // Back: character output.
  i2d_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .dig_valid  (dig_valid),
    .dig_ready  (dig_ready),
    .dig        (dig),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A minus sign never ends a number.
  `I2D_ASSERT(a_minus_not_last, (out_tvalid && out_tdata == CHAR_MINUS) |-> !out_tlast, "minus sign marked last")
  // Only a minus sign or a decimal digit leaves the block.
  `I2D_ASSERT(a_char_legal, out_tvalid |-> (out_tdata == CHAR_MINUS || (out_tdata >= CHAR_ZERO && out_tdata <= CHAR_NINE)), "illegal output character")
  // The queue never holds more than its depth.
  `I2D_ASSERT(a_fill_bound, q_fill <= Q_CW'(Q_DEPTH), "queue fill beyond depth")
  // The output register is empty right after a reset cycle.
  `I2D_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_tvalid, "output valid after reset")

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to decimal ASCII converter. A table
// of directed values runs first: extremes, zero, one-digit and ten-digit
// boundaries, and the most negative value, with the text typed in where
// it is obvious. Random values follow, weighted toward short numbers and
// powers of ten. Every accepted input beat adds its expected characters to
// a queue, and every output beat is checked against the oldest entry.
// Both sides idle at random, and the output is held off once for a long
// stretch so that the input stalls.
// ---------------------------------------------------------------------------
module tb_top;
  import i2d_pkg::*;

  // One expected output beat: character and end-of-number flag.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  // Directed row: value and its text, or an empty text to use the predictor.
  typedef struct {
    logic [IN_TDATA_W-1:0] value;
    string                 text;
  } text_row_t;

  localparam int NUM_ROWS    = 20;
  localparam int NUM_RANDOM  = 460;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE_CYC  = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CHAR_W-1:0]     out_tdata;
  logic                  out_tlast;

  char_beat_t pending_chars[$];
  int         errors;
  bit         no_idle;
  bit         hold_req;

  text_row_t dir_rows [NUM_ROWS] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'hFFFF_FFFF,  "-1"},
    '{32'hFFFF_FFF6,  "-10"},
    '{32'h7FFF_FFFF,  "2147483647"},
    '{32'h8000_0000,  "-2147483648"},
    '{32'h8000_0001,  "-2147483647"},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{32'hC465_3600,  "-1000000000"},
    '{32'h5555_5555,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'd99,         ""},
    '{32'd100,        ""},
    '{32'hFFFF_FF9C,  ""},
    '{32'd12345,      ""},
    '{32'h7FFF_FFFE,  ""},
    '{32'hF0F0_F0F0,  ""}
  };

  int_to_decimal_ascii dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Clock with a period of 8.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle cycles before the next beat on either side.
  function automatic int idle_gap();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // Expected text of a signed value: optional minus, then digits MSD first.
  task automatic predict_text(input logic [IN_TDATA_W-1:0] value);
    logic              neg;
    logic [31:0]       mag;
    logic [CHAR_W-1:0] digs[$];
    int                i;
    neg = value[31];
    mag = neg ? (~value[31:0] + 32'd1) : value[31:0];
    do begin
      digs.push_back(CHAR_ZERO + 8'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    if (neg)
      pending_chars.push_back('{CHAR_MINUS, 1'b0});
    for (i = digs.size() - 1; i >= 0; i--)
      pending_chars.push_back('{digs[i], (i == 0)});
  endtask

  // Expected characters copied from a typed-in string.
  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      pending_chars.push_back('{s[i], (i == s.len() - 1)});
  endtask

  // Offer one value and wait for its beat to be taken.
  task automatic send_value(input logic [IN_TDATA_W-1:0] v, input string text);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    if (text.len() > 0)
      push_text(text);
    else
      predict_text(v);
  endtask

  // Drop the input and wait until every expected character has arrived.
  task automatic drain_outputs();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Random value: full range, short numbers, powers of ten and extremes.
  function automatic logic [IN_TDATA_W-1:0] random_value();
    int unsigned           sel;
    int unsigned           k;
    logic [IN_TDATA_W-1:0] v;
    logic [IN_TDATA_W-1:0] p;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        return $urandom;
      end
      4, 5: begin
        v = $urandom_range(0, 99);
      end
      6: begin
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
      end
      7: begin
        return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 15)
                                    : 32'h8000_0000 + $urandom_range(0, 15);
      end
      default: begin
        v = $urandom_range(0, 1000000);
      end
    endcase
    if ($urandom_range(0, 1))
      v = -v;
    return v;
  endfunction

  // Output side: random stalls, plus one long hold when requested.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = idle_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Check each output beat against the oldest expected character.
  always @(posedge clk) begin
    char_beat_t exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat char=%0d last=%0b",
                 $time, out_tdata, out_tlast);
      end else begin
        exp_beat = pending_chars.pop_front();
        if (out_tdata !== exp_beat.ch) begin
          errors++;
          $display("%0t: char expected %0d actual %0d",
                   $time, exp_beat.ch, out_tdata);
        end
        if (out_tlast !== exp_beat.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b",
                   $time, exp_beat.last, out_tlast);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final check.
  initial begin
    int n;
    errors    = 0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < NUM_ROWS; n++)
      send_value(dir_rows[n].value, dir_rows[n].text);

    for (n = 0; n < NUM_RANDOM; n++) begin
      // A stretch without idling on either side.
      no_idle = (n >= 150 && n < 230);
      // The output holds off while input keeps coming.
      if (n == 100)
        hold_req = 1'b1;
      // The input pauses until the output has caught up.
      if (n == 300)
        drain_outputs();
      send_value(random_value(), "");
    end

    drain_outputs();
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("int_to_decimal_ascii: match");
    end else begin
      $display("int_to_decimal_ascii: mismatch");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2500000;
    $display("int_to_decimal_ascii: mismatch");
    $finish;
  end

endmodule
